[src/atl_pkg.sv]
package atl_pkg;

  // Field widths fixed by the interface
  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 4;
  localparam int unsigned LineW = 16;
  localparam int unsigned LenW  = 6;

  // Token length limit default (a token holds at most this minus one chars)
  localparam int unsigned MaxTokenLenDefault = 32;

  // Token kinds
  typedef enum logic [KindW-1:0] {
    TK_TOOLONG = 4'd0,
    TK_LABEL   = 4'd1,
    TK_NAME    = 4'd2,
    TK_NUMBER  = 4'd3,
    TK_SHARP   = 4'd4,
    TK_AT      = 4'd5,
    TK_OPEN    = 4'd6,
    TK_CLOSE   = 4'd7,
    TK_NEWLINE = 4'd8,
    TK_END     = 4'd9,
    TK_INVALID = 4'd10
  } tok_kind_e;

  // Event kinds
  localparam logic EV_TEXT = 1'b0;
  localparam logic EV_DONE = 1'b1;

  // Special characters
  localparam logic [ByteW-1:0] CH_SEMI  = 8'h3B;
  localparam logic [ByteW-1:0] CH_SHARP = 8'h23;
  localparam logic [ByteW-1:0] CH_AT    = 8'h40;
  localparam logic [ByteW-1:0] CH_OPEN  = 8'h5B;
  localparam logic [ByteW-1:0] CH_CLOSE = 8'h5D;
  localparam logic [ByteW-1:0] CH_COLON = 8'h3A;
  localparam logic [ByteW-1:0] CH_NL    = 8'h0A;

  // One result
  typedef struct packed {
    logic             event_kind;
    tok_kind_e        token_kind;
    logic [ByteW-1:0] text_char;
    logic [LineW-1:0] line_number;
  } result_t;

  // All results of one item: first always present, second optional
  typedef struct packed {
    logic    has_second;
    result_t first;
    result_t second;
  } packet_t;

endpackage

[src/assembly_token_lexer.sv]
// Assembler lexer: takes one source byte (or an end-of-input mark) per item
// and produces token events: one per token character, one per completed
// token, each tagged with the current line number and a flag on the last
// result of its item. The front end classifies one item per cycle while the
// queue is not full and queues its results (up to two) in a two-entry queue;
// the back end delivers one result per cycle, unless stalled, through a
// registered output. An item's first result passes through the queue and
// then the output register. Sustained rate is one item per cycle without
// output stalls. An end-of-input item that closes an open name, number or
// comment has two results, which the single output register delivers in turn.
module assembly_token_lexer #(
  parameter int unsigned MaxTokenLen = atl_pkg::MaxTokenLenDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [atl_pkg::ByteW-1:0] source_byte_i,
  input  logic                      end_of_input_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      event_kind_o,
  output logic [atl_pkg::KindW-1:0] token_kind_o,
  output logic [atl_pkg::ByteW-1:0] text_char_o,
  output logic [atl_pkg::LineW-1:0] line_number_o,
  output logic                      last_result_o
);
  import atl_pkg::*;

  logic    full, push, pop, head_valid;
  packet_t push_data, head_data;

  atl_front #(
    .MaxTokenLen(MaxTokenLen)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .source_byte_i (source_byte_i),
    .end_of_input_i(end_of_input_i),
    .full_i        (full),
    .push_o        (push),
    .packet_o      (push_data)
  );

  atl_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_data_o (head_data)
  );

  atl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_data_i  (head_data),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .event_kind_o (event_kind_o),
    .token_kind_o (token_kind_o),
    .text_char_o  (text_char_o),
    .line_number_o(line_number_o),
    .last_result_o(last_result_o)
  );

endmodule

[src/atl_front.sv]
module atl_front #(
  parameter int unsigned MaxTokenLen = atl_pkg::MaxTokenLenDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [atl_pkg::ByteW-1:0] source_byte_i,
  input  logic                     end_of_input_i,
  input  logic                     full_i,
  output logic                     push_o,
  output atl_pkg::packet_t         packet_o
);
  import atl_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_NAME    = 2'd1,
    MODE_NUMBER  = 2'd2,
    MODE_COMMENT = 2'd3
  } mode_e;

  localparam logic [LenW-1:0] LenLimit = LenW'(MaxTokenLen - 1);

  mode_e            mode_q, mode_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [LineW-1:0] line_q, line_d;
  logic             done_q, done_d;

  logic             accept;
  logic [ByteW-1:0] ch;
  logic             is_letter, is_dec, is_hex, is_blank, member;
  logic [1:0]       n_res;
  result_t          r0, r1;

  assign accept     = in_valid_i && !full_i;
  assign in_stall_o = full_i;

  // Fold to upper case and classify
  always_comb begin
    ch = source_byte_i;
    if (source_byte_i >= 8'h61 && source_byte_i <= 8'h7A) begin
      ch = source_byte_i - 8'h20;
    end
    is_letter = (ch >= 8'h41) && (ch <= 8'h5A);
    is_dec    = (ch >= 8'h30) && (ch <= 8'h39);
    is_hex    = is_dec || ((ch >= 8'h41) && (ch <= 8'h46));
    is_blank  = (ch == 8'h20) || (ch == 8'h09) || (ch == 8'h0B) ||
                (ch == 8'h0C) || (ch == 8'h0D);
    member    = (mode_q == MODE_NAME) ? (is_letter || is_dec) : is_hex;
  end

  // Next state and results of the current item
  always_comb begin
    mode_d = mode_q;
    len_d  = len_q;
    line_d = line_q;
    done_d = done_q;
    n_res  = 2'd0;
    r0     = '{event_kind: EV_DONE, token_kind: TK_END, text_char: '0, line_number: '0};
    r1     = r0;

    if (done_q) begin
      n_res = 2'd1;
    end else if (end_of_input_i) begin
      unique case (mode_q)
        MODE_NAME: begin
          r0.token_kind = TK_NAME;
          n_res = 2'd2;
        end
        MODE_NUMBER: begin
          r0.token_kind = TK_NUMBER;
          n_res = 2'd2;
        end
        MODE_COMMENT: begin
          line_d = line_q + 1'b1;
          r0.token_kind = TK_NEWLINE;
          n_res = 2'd2;
        end
        default: begin
          n_res = 2'd1;
        end
      endcase
      mode_d = MODE_IDLE;
      len_d  = '0;
      done_d = 1'b1;
    end else begin
      unique case (mode_q)
        MODE_NAME, MODE_NUMBER: begin
          n_res = 2'd1;
          if (member) begin
            if (len_q >= LenLimit) begin
              r0.token_kind = TK_TOOLONG;
              mode_d = MODE_IDLE;
              len_d  = '0;
            end else begin
              r0.event_kind = EV_TEXT;
              r0.token_kind = (mode_q == MODE_NAME) ? TK_NAME : TK_NUMBER;
              r0.text_char  = ch;
              len_d = len_q + 1'b1;
            end
          end else begin
            if (mode_q == MODE_NAME) begin
              r0.token_kind = (ch == CH_COLON) ? TK_LABEL : TK_NAME;
            end else begin
              r0.token_kind = TK_NUMBER;
            end
            mode_d = MODE_IDLE;
            len_d  = '0;
          end
        end
        MODE_COMMENT: begin
          if (ch == CH_NL) begin
            line_d = line_q + 1'b1;
            r0.token_kind = TK_NEWLINE;
            n_res  = 2'd1;
            mode_d = MODE_IDLE;
          end
        end
        default: begin
          if (is_blank) begin
            n_res = 2'd0;
          end else if (is_letter || is_dec) begin
            // Token start: first char is taken unchecked (the limit is assumed to be at least one)
            r0.event_kind = EV_TEXT;
            r0.token_kind = is_letter ? TK_NAME : TK_NUMBER;
            r0.text_char  = ch;
            n_res  = 2'd1;
            mode_d = is_letter ? MODE_NAME : MODE_NUMBER;
            len_d  = LenW'(1);
          end else if (ch == CH_SEMI) begin
            mode_d = MODE_COMMENT;
          end else begin
            n_res = 2'd1;
            case (ch)
              CH_SHARP: r0.token_kind = TK_SHARP;
              CH_AT:    r0.token_kind = TK_AT;
              CH_OPEN:  r0.token_kind = TK_OPEN;
              CH_CLOSE: r0.token_kind = TK_CLOSE;
              CH_NL: begin
                line_d = line_q + 1'b1;
                r0.token_kind = TK_NEWLINE;
              end
              default: begin
                r0.token_kind = TK_INVALID;
                r0.text_char  = ch;
              end
            endcase
          end
        end
      endcase
    end

    r0.line_number = line_d;
    r1.line_number = line_d;
  end

  assign push_o              = accept && (n_res != 2'd0);
  assign packet_o.has_second = (n_res == 2'd2);
  assign packet_o.first      = r0;
  assign packet_o.second     = r1;

  // Lexer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      len_q  <= '0;
      line_q <= LineW'(1);
      done_q <= 1'b0;
    end else if (accept) begin
      mode_q <= mode_d;
      len_q  <= len_d;
      line_q <= line_d;
      done_q <= done_d;
    end
  end

endmodule

[src/atl_queue.sv]
module atl_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  atl_pkg::packet_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             head_valid_o,
  output atl_pkg::packet_t head_data_o
);
  import atl_pkg::*;

  localparam int unsigned Depth = 2;

  packet_t    mem_q [Depth];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o       = (count_q == 2'(Depth));
  assign head_valid_o = (count_q != 2'd0);
  assign head_data_o  = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

[src/atl_back.sv]
module atl_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      head_valid_i,
  input  atl_pkg::packet_t          head_data_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      event_kind_o,
  output logic [atl_pkg::KindW-1:0] token_kind_o,
  output logic [atl_pkg::ByteW-1:0] text_char_o,
  output logic [atl_pkg::LineW-1:0] line_number_o,
  output logic                      last_result_o
);
  import atl_pkg::*;

  logic    valid_q;
  logic    sub_q;
  result_t res_q, res_d;
  logic    last_q, last_d;
  logic    load;

  // Output register takes a new result when empty or being drained
  assign load = head_valid_i && (!valid_q || !out_stall_i);

  always_comb begin
    if (sub_q) begin
      res_d  = head_data_i.second;
      last_d = 1'b1;
    end else begin
      res_d  = head_data_i.first;
      last_d = !head_data_i.has_second;
    end
  end

  // Packet leaves the queue with its last result
  assign pop_o = load && last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sub_q   <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        sub_q   <= !last_d;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q  <= res_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o   = valid_q;
  assign event_kind_o  = res_q.event_kind;
  assign token_kind_o  = res_q.token_kind;
  assign text_char_o   = res_q.text_char;
  assign line_number_o = res_q.line_number;
  assign last_result_o = last_q;

endmodule
